/* rtl/amrb_pkg.sv */
// ----------------------------------------------------------------------------
// amrb_pkg - shared types and constants of the audio mixing ring buffer
// Field widths, register indexes, function and status codes, and the command
// word that travels from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package amrb_pkg;

  // configuration port
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLES_PER_FRAME = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_PERIOD      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BUFFER_LENGTH     = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_TIME        = 2'd3;

  // field widths
  localparam int SPF_W    = 13;
  localparam int PERIOD_W = 10;
  localparam int BLEN_W   = 13;
  localparam int TIME_W   = 32;
  localparam int INDEX_W  = 12;
  localparam int NSAMP_W  = 13;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;

  // register reset values
  localparam logic [SPF_W-1:0]    SPF_RESET    = 13'd80;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd10;
  localparam logic [BLEN_W-1:0]   BLEN_RESET   = 13'd800;
  localparam logic [TIME_W-1:0]   START_RESET  = 32'd0;

  // function codes
  localparam logic [FUNC_W-1:0] FUNC_MIX_TIME  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_MIX_START = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ      = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_RESTART   = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_LATE   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BEYOND = 2'd2;

  // command queue and divider
  localparam int QUEUE_DEPTH = 2;
  localparam int DIV_W       = 32;
  localparam int DIV_STEP_W  = 6;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic               idx_bad;
    logic [TIME_W-1:0]  frame_time;
    logic [INDEX_W-1:0] sample_index;
    logic [NSAMP_W-1:0] frame_samples;
  } amrb_cmd_t;

endpackage

/* rtl/amrb_if.sv */
// ----------------------------------------------------------------------------
// amrb_if - request and response channels of the audio mixing ring buffer
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface amrb_req_if import amrb_pkg::*; #(parameter int SAMPLE_WIDTH = 16);
  logic                           valid;
  logic                           ready;
  logic [FUNC_W-1:0]              func;
  logic [TIME_W-1:0]              frame_time;
  logic [INDEX_W-1:0]             sample_index;
  logic [NSAMP_W-1:0]             frame_samples;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, func, frame_time, sample_index, frame_samples, sample_in,
                  input ready);
  modport sink   (input valid, func, frame_time, sample_index, frame_samples, sample_in,
                  output ready);
endinterface

interface amrb_rsp_if import amrb_pkg::*; #(parameter int SAMPLE_WIDTH = 16);
  logic                           valid;
  logic                           ready;
  logic [STATUS_W-1:0]            status;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic [TIME_W-1:0]              current_time;
  logic                           frame_end;

  modport source (output valid, status, sample_out, current_time, frame_end, input ready);
  modport sink   (input valid, status, sample_out, current_time, frame_end, output ready);
endinterface

/* rtl/amrb_front.sv */
// ----------------------------------------------------------------------------
// amrb_front - request front end
// Accepts request beats, flags a sample index outside its frame and holds the
// classified command in a register until the queue takes it.
// ----------------------------------------------------------------------------
module amrb_front import amrb_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  amrb_req_if.sink                req,
  output logic                    cmd_valid,
  input  logic                    cmd_ready,
  output amrb_cmd_t               cmd,
  output logic [SAMPLE_WIDTH-1:0] cmd_sample
);

  // take a new beat whenever the stage is empty or drains this cycle
  assign req.ready = !cmd_valid || cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (req.ready) begin
      cmd_valid <= req.valid;
    end
  end

  // classify and hold the payload
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cmd.func          <= req.func;
      cmd.idx_bad       <= {1'b0, req.sample_index} >= req.frame_samples;
      cmd.frame_time    <= req.frame_time;
      cmd.sample_index  <= req.sample_index;
      cmd.frame_samples <= req.frame_samples;
      cmd_sample        <= req.sample_in;
    end
  end

endmodule

/* rtl/amrb_queue.sv */
// ----------------------------------------------------------------------------
// amrb_queue - short command queue
// Decouples the front end from the back end so that each can stall alone.
// ----------------------------------------------------------------------------
module amrb_queue import amrb_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]  slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign in_ready  = count != CW'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_data  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  // store the incoming beat
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

endmodule

/* rtl/amrb_div.sv */
// ----------------------------------------------------------------------------
// amrb_div - iterative restoring divider
// One quotient bit a cycle. The dividend is taken from its top bit down for
// the given number of steps, so a short value may be left-aligned and run in
// fewer steps when only the remainder is wanted.
// ----------------------------------------------------------------------------
module amrb_div import amrb_pkg::*; #(
  parameter int DW = 17
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIV_W-1:0]      dividend,
  input  logic [DW-1:0]         divisor,
  input  logic [DIV_STEP_W-1:0] steps,
  output logic                  busy,
  output logic                  done,
  output logic [DIV_W-1:0]      quotient,
  output logic [DW-1:0]         remainder
);

  logic [DIV_W-1:0]      dvd;
  logic [DW-1:0]         dsr;
  logic [DIV_STEP_W-1:0] cnt;
  logic [DW:0]           trial;
  logic                  fits;

  assign trial = {remainder, dvd[DIV_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  // sequence the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == DIV_STEP_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= steps;
      end else if (busy) begin
        cnt <= cnt - DIV_STEP_W'(1);
        if (cnt == DIV_STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // shift, trial subtract, restore
  always_ff @(posedge clk) begin
    if (start) begin
      dvd       <= dividend;
      dsr       <= divisor;
      quotient  <= '0;
      remainder <= '0;
    end else if (busy) begin
      dvd      <= {dvd[DIV_W-2:0], 1'b0};
      quotient <= {quotient[DIV_W-2:0], fits};
      if (fits) begin
        remainder <= DW'(trial - {1'b0, dsr});
      end else begin
        remainder <= trial[DW-1:0];
      end
    end
  end

endmodule

/* rtl/amrb_back.sv */
// ----------------------------------------------------------------------------
// amrb_back - execution back end
// Holds the configuration, the sample store and the ring state, carries out
// one command at a time and loads the response register.
// ----------------------------------------------------------------------------
module amrb_back import amrb_pkg::*; #(
  parameter int BUFFER_DEPTH = 4096,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  logic [CFG_INDEX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0]   wr_data,
  input  logic                    cmd_valid,
  output logic                    cmd_ready,
  input  amrb_cmd_t               cmd,
  input  logic [SAMPLE_WIDTH-1:0] cmd_sample,
  amrb_rsp_if.source              rsp
);

  localparam int AW    = $clog2(BUFFER_DEPTH);
  localparam int LW    = $clog2(BUFFER_DEPTH + 1);
  localparam int SW    = LW + 1;
  localparam int DW    = (LW > PERIOD_W) ? LW : PERIOD_W;
  localparam int OFF_W = TIME_W + SPF_W;
  localparam int CMP_W = OFF_W + 1;

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_DIV_Q   = 4'd2;
  localparam logic [3:0] S_CHECK   = 4'd3;
  localparam logic [3:0] S_SLOT    = 4'd4;
  localparam logic [3:0] S_DIV_R   = 4'd5;
  localparam logic [3:0] S_MEM_RD  = 4'd6;
  localparam logic [3:0] S_MEM_WR  = 4'd7;
  localparam logic [3:0] S_RD_DATA = 4'd8;
  localparam logic [3:0] S_DIV_B   = 4'd9;
  localparam logic [3:0] S_DONE    = 4'd10;

  // configuration registers
  logic [SPF_W-1:0]    cfg_spf;
  logic [PERIOD_W-1:0] cfg_period;
  logic [BLEN_W-1:0]   cfg_blen;
  logic [TIME_W-1:0]   cfg_start;

  // control state
  logic [3:0]          state;
  logic [AW-1:0]       clr_addr;
  logic                clr_result;
  logic [AW-1:0]       ring_begin;
  logic [SPF_W-1:0]    frame_phase;
  logic [TIME_W-1:0]   now_time;
  logic                out_valid;

  // working registers
  logic [FUNC_W-1:0]       w_func;
  logic [INDEX_W-1:0]      w_idx;
  logic [NSAMP_W-1:0]      w_nsamp;
  logic [SAMPLE_WIDTH-1:0] w_value;
  logic [OFF_W-1:0]        offset;
  logic [SW-1:0]           sum;
  logic [AW-1:0]           slot;
  logic [STATUS_W-1:0]     res_status;
  logic [SAMPLE_WIDTH-1:0] res_sample;
  logic                    res_fend;
  logic [STATUS_W-1:0]     out_status;
  logic [SAMPLE_WIDTH-1:0] out_sample;
  logic [TIME_W-1:0]       out_time;
  logic                    out_fend;

  // derived values
  logic [SPF_W-1:0]    spf_eff;
  logic [PERIOD_W-1:0] per_eff;
  logic [LW-1:0]       ring_len;
  logic [SW-1:0]       len_dbl;
  logic                len_zero;
  logic [TIME_W-1:0]   diff;
  logic                over;
  logic [SW-1:0]       s_sum;
  logic [LW-1:0]       p1;
  logic [SPF_W-1:0]    ph1;

  // divider hookup
  logic                  div_start;
  logic [DIV_W-1:0]      div_dividend;
  logic [DW-1:0]         div_divisor;
  logic [DIV_STEP_W-1:0] div_steps;
  logic                  div_busy;
  logic                  div_done;
  logic [DIV_W-1:0]      div_quotient;
  logic [DW-1:0]         div_remainder;

  // sample store
  logic [SAMPLE_WIDTH-1:0] mem [BUFFER_DEPTH];
  logic [SAMPLE_WIDTH-1:0] mem_rdata;
  logic [SAMPLE_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]           mem_waddr;
  logic                    mem_we;
  logic                    mem_re;

  // write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_spf    <= SPF_RESET;
      cfg_period <= PERIOD_RESET;
      cfg_blen   <= BLEN_RESET;
      cfg_start  <= START_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_SAMPLES_PER_FRAME: cfg_spf    <= wr_data[SPF_W-1:0];
        CFG_FRAME_PERIOD:      cfg_period <= wr_data[PERIOD_W-1:0];
        CFG_BUFFER_LENGTH:     cfg_blen   <= wr_data[BLEN_W-1:0];
        CFG_START_TIME:        cfg_start  <= wr_data[TIME_W-1:0];
      endcase
    end
  end

  // effective settings: a zero period or frame size counts as one
  assign spf_eff  = (cfg_spf == '0) ? SPF_W'(1) : cfg_spf;
  assign per_eff  = (cfg_period == '0) ? PERIOD_W'(1) : cfg_period;
  assign ring_len = (32'(cfg_blen) < 32'(BUFFER_DEPTH)) ? LW'(cfg_blen) : LW'(BUFFER_DEPTH);
  assign len_dbl  = {ring_len, 1'b0};
  assign len_zero = ring_len == '0;

  assign diff  = cmd.frame_time - now_time;
  assign over  = (CMP_W'(offset) + CMP_W'(w_nsamp)) > CMP_W'(ring_len);
  assign s_sum = SW'(ring_begin) + SW'(offset) + SW'(w_idx);
  assign p1    = LW'(slot) + LW'(1);
  assign ph1   = frame_phase + SPF_W'(1);

  assign cmd_ready = (state == S_IDLE) && !out_valid;

  // launch the shared divider: frame offset, slot wrap or begin wrap
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    div_steps    = '0;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid && cmd_ready && cmd.func == FUNC_MIX_TIME && !diff[TIME_W-1] &&
            !cmd.idx_bad && !len_zero) begin
          div_start    = 1'b1;
          div_dividend = diff;
          div_divisor  = DW'(per_eff);
          div_steps    = DIV_STEP_W'(DIV_W);
        end
      end
      S_SLOT: begin
        if (sum >= len_dbl) begin
          div_start    = 1'b1;
          div_dividend = {sum, {(DIV_W - SW){1'b0}}};
          div_divisor  = DW'(ring_len);
          div_steps    = DIV_STEP_W'(SW);
        end
      end
      S_RD_DATA: begin
        if (!len_zero && p1 > ring_len) begin
          div_start    = 1'b1;
          div_dividend = {SW'(p1), {(DIV_W - SW){1'b0}}};
          div_divisor  = DW'(ring_len);
          div_steps    = DIV_STEP_W'(SW);
        end
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  amrb_div #(.DW(DW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .steps     (div_steps),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  // store port control: clear sweep, mix write-back, read-and-clear
  always_comb begin
    mem_re    = state == S_MEM_RD;
    mem_we    = 1'b0;
    mem_waddr = slot;
    mem_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
      end
      S_MEM_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata + w_value;
      end
      S_RD_DATA: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[slot];
    end
  end

  // sequence one command
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      clr_result  <= 1'b0;
      ring_begin  <= '0;
      frame_phase <= '0;
      now_time    <= START_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (clr_addr == AW'(BUFFER_DEPTH - 1)) begin
            clr_addr <= '0;
            state    <= clr_result ? S_DONE : S_IDLE;
          end else begin
            clr_addr <= clr_addr + AW'(1);
          end
        end
        S_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            w_func     <= cmd.func;
            w_idx      <= cmd.sample_index;
            w_nsamp    <= cmd.frame_samples;
            w_value    <= cmd_sample;
            res_sample <= '0;
            res_fend   <= 1'b0;
            unique case (cmd.func)
              FUNC_MIX_TIME: begin
                if (diff[TIME_W-1]) begin
                  res_status <= STATUS_LATE;
                  state      <= S_DONE;
                end else if (cmd.idx_bad || len_zero) begin
                  res_status <= STATUS_BEYOND;
                  state      <= S_DONE;
                end else begin
                  res_status <= STATUS_OK;
                  state      <= S_DIV_Q;
                end
              end
              FUNC_MIX_START: begin
                if (cmd.idx_bad || len_zero) begin
                  res_status <= STATUS_BEYOND;
                  state      <= S_DONE;
                end else begin
                  res_status <= STATUS_OK;
                  offset     <= '0;
                  state      <= S_CHECK;
                end
              end
              FUNC_READ: begin
                res_status <= STATUS_OK;
                slot       <= ring_begin;
                state      <= S_MEM_RD;
              end
              FUNC_RESTART: begin
                res_status  <= STATUS_OK;
                ring_begin  <= '0;
                frame_phase <= '0;
                now_time    <= cfg_start;
                clr_addr    <= '0;
                clr_result  <= 1'b1;
                state       <= S_CLEAR;
              end
            endcase
          end
        end
        S_DIV_Q: begin
          // scale whole frames ahead to samples
          if (div_done) begin
            offset <= div_quotient * spf_eff;
            state  <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (over) begin
            res_status <= STATUS_BEYOND;
            state      <= S_DONE;
          end else begin
            sum   <= s_sum;
            state <= S_SLOT;
          end
        end
        S_SLOT: begin
          // wrap the slot: one subtract in the usual case, else divide
          if (sum < SW'(ring_len)) begin
            slot  <= AW'(sum);
            state <= S_MEM_RD;
          end else if (sum < len_dbl) begin
            slot  <= AW'(sum - SW'(ring_len));
            state <= S_MEM_RD;
          end else begin
            state <= S_DIV_R;
          end
        end
        S_DIV_R: begin
          if (div_done) begin
            slot  <= AW'(div_remainder);
            state <= S_MEM_RD;
          end
        end
        S_MEM_RD: begin
          state <= (w_func == FUNC_READ) ? S_RD_DATA : S_MEM_WR;
        end
        S_MEM_WR: begin
          state <= S_DONE;
        end
        S_RD_DATA: begin
          res_sample <= mem_rdata;
          if (ph1 >= spf_eff) begin
            frame_phase <= '0;
            now_time    <= now_time + TIME_W'(per_eff);
            res_fend    <= 1'b1;
          end else begin
            frame_phase <= ph1;
          end
          // advance the ring start
          if (len_zero) begin
            ring_begin <= '0;
            state      <= S_DONE;
          end else if (p1 < ring_len) begin
            ring_begin <= AW'(p1);
            state      <= S_DONE;
          end else if (p1 == ring_len) begin
            ring_begin <= '0;
            state      <= S_DONE;
          end else begin
            state <= S_DIV_B;
          end
        end
        S_DIV_B: begin
          if (div_done) begin
            ring_begin <= AW'(div_remainder);
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          out_valid  <= 1'b1;
          out_status <= res_status;
          out_sample <= res_sample;
          out_time   <= now_time;
          out_fend   <= res_fend;
          clr_result <= 1'b0;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.sample_out   = out_sample;
  assign rsp.current_time = out_time;
  assign rsp.frame_end    = out_fend;

  // the divider is never restarted mid-run
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // a response is loaded only into an empty output register
  a_done_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> !out_valid)
    else $error("response register overwritten");

  // a new response appears only after the completion step
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("response raised outside completion");

  // frame time moves only on a read or a restart
  a_time_move: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (now_time != $past(now_time))) |->
      ($past(state) == S_RD_DATA || $past(state) == S_IDLE))
    else $error("frame time changed outside read or restart");

endmodule

/* rtl/audio_mix_ring_buffer_unit.sv */
// ----------------------------------------------------------------------------
// audio_mix_ring_buffer_unit - circular audio mixing buffer
// Front end, command queue and execution back end of the mixing ring.
// ----------------------------------------------------------------------------
// Requests enter through a registered front end and a two-entry queue, so a
// new request is taken while the back end works or a response waits; the back
// end executes one command at a time and gives exactly one response for each.
// A read and a mix at ring start each run through the single-port store's
// read-modify-write. A mix at frame time first passes through the shared
// radix-2 divider, which turns the time ahead into whole frames. When
// buffer_length has shrunk below the ring start, the slot or start wrap goes
// through the same divider. After reset and after every restart the store is
// swept to zero, one entry a cycle; no request is executed meanwhile, while
// configuration writes are taken as ever. A restart's response follows its
// sweep.
// ----------------------------------------------------------------------------
module audio_mix_ring_buffer_unit import amrb_pkg::*; #(
  parameter int BUFFER_DEPTH = 4096,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data,
  amrb_req_if.sink               req,
  amrb_rsp_if.source             rsp
);

  localparam int CMD_W = $bits(amrb_cmd_t);
  localparam int QW    = CMD_W + SAMPLE_WIDTH;

  logic                    f_valid;
  logic                    f_ready;
  amrb_cmd_t               f_cmd;
  logic [SAMPLE_WIDTH-1:0] f_sample;
  logic                    q_valid;
  logic                    q_ready;
  logic [QW-1:0]           q_data;
  amrb_cmd_t               q_cmd;
  logic [SAMPLE_WIDTH-1:0] q_sample;

  amrb_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .cmd_valid  (f_valid),
    .cmd_ready  (f_ready),
    .cmd        (f_cmd),
    .cmd_sample (f_sample)
  );

  amrb_queue #(.W(QW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   ({f_cmd, f_sample}),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_data)
  );

  // split the queued beat back into command and sample
  assign q_cmd    = q_data[QW-1 -: CMD_W];
  assign q_sample = q_data[SAMPLE_WIDTH-1:0];

  amrb_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .cmd_valid  (q_valid),
    .cmd_ready  (q_ready),
    .cmd        (q_cmd),
    .cmd_sample (q_sample),
    .rsp        (rsp)
  );

endmodule

/* tb/amrb_mix_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amrb_mix_checker - response predictor and scoreboard for the mixing ring
// Watches the register port and both channels, keeps its own copy of the
// ring, frame clock and registers, predicts the response of every accepted
// request and compares each response beat field by field, in order.
// ----------------------------------------------------------------------------
module amrb_mix_checker import amrb_pkg::*; #(
  parameter int DEPTH = 4096,
  parameter int SW    = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data,
  amrb_req_if                    req,
  amrb_rsp_if                    rsp,
  output int                     mismatches,
  output int                     outstanding,
  output int                     compared
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SW-1:0]       sample;
    logic [TIME_W-1:0]   current_time;
    logic                frame_end;
  } outcome_t;

  // register copies
  logic [SPF_W-1:0]    spf_reg;
  logic [PERIOD_W-1:0] period_reg;
  logic [BLEN_W-1:0]   blen_reg;
  logic [TIME_W-1:0]   start_reg;

  // ring state
  logic [SW-1:0]       ring [DEPTH];
  int unsigned         head;
  int unsigned         phase;
  logic [TIME_W-1:0]   now;

  outcome_t            awaited_responses [$];

  function automatic int unsigned ring_span();
    return (blen_reg < DEPTH) ? int'(blen_reg) : DEPTH;
  endfunction

  function automatic int unsigned per_step();
    return (period_reg == '0) ? 1 : int'(period_reg);
  endfunction

  function automatic int unsigned frame_size();
    return (spf_reg == '0) ? 1 : int'(spf_reg);
  endfunction

  function automatic void clear_ring();
    for (int i = 0; i < DEPTH; i++) ring[i] = '0;
  endfunction

  // add one sample into the ring at start + offset + index, if it fits
  function automatic logic [STATUS_W-1:0] add_sample(longint unsigned offset,
      int unsigned idx, int unsigned nsamp, logic [SW-1:0] value);
    longint unsigned len;
    longint unsigned slot;
    len = ring_span();
    if (idx >= nsamp || len == 0) return STATUS_BEYOND;
    if (offset + nsamp > len) return STATUS_BEYOND;
    slot = head;
    slot = (slot + offset + idx) % len;
    ring[slot] = ring[slot] + value;
    return STATUS_OK;
  endfunction

  // work out the response of one request and advance the ring state
  function automatic outcome_t ring_response(logic [FUNC_W-1:0] func,
      logic [TIME_W-1:0] ftime, logic [INDEX_W-1:0] idx,
      logic [NSAMP_W-1:0] nsamp, logic [SW-1:0] value);
    outcome_t          o;
    logic [TIME_W-1:0] ahead;
    longint unsigned   offset;
    int unsigned       pos;
    int unsigned       len;
    o = '0;
    case (func)
      FUNC_MIX_TIME: begin
        ahead = ftime - now;
        if (ahead[TIME_W-1]) begin
          o.status = STATUS_LATE;
        end else begin
          offset = ahead / per_step();
          offset = offset * frame_size();
          o.status = add_sample(offset, idx, nsamp, value);
        end
      end
      FUNC_MIX_START: begin
        o.status = add_sample(0, idx, nsamp, value);
      end
      FUNC_READ: begin
        // take and clear the start slot, then move the start on
        pos = head % DEPTH;
        o.sample = ring[pos];
        ring[pos] = '0;
        len = ring_span();
        head = (len != 0) ? (pos + 1) % len : 0;
        phase++;
        if (phase >= frame_size()) begin
          phase = 0;
          now = now + per_step();
          o.frame_end = 1'b1;
        end
      end
      FUNC_RESTART: begin
        clear_ring();
        head = 0;
        phase = 0;
        now = start_reg;
      end
    endcase
    o.current_time = now;
    return o;
  endfunction

  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (rst) begin
      spf_reg = SPF_RESET;
      period_reg = PERIOD_RESET;
      blen_reg = BLEN_RESET;
      start_reg = START_RESET;
      clear_ring();
      head = 0;
      phase = 0;
      now = START_RESET;
      awaited_responses.delete();
      mismatches = 0;
      compared = 0;
    end else begin
      // register writes
      if (wr_en) begin
        case (wr_index)
          CFG_SAMPLES_PER_FRAME: spf_reg = wr_data[SPF_W-1:0];
          CFG_FRAME_PERIOD:      period_reg = wr_data[PERIOD_W-1:0];
          CFG_BUFFER_LENGTH:     blen_reg = wr_data[BLEN_W-1:0];
          CFG_START_TIME:        start_reg = wr_data[TIME_W-1:0];
        endcase
      end
      // request beat: predict
      if (req.valid && req.ready) begin
        awaited_responses.push_back(ring_response(req.func, req.frame_time,
            req.sample_index, req.frame_samples, req.sample_in));
      end
      // response beat: compare with the oldest prediction
      if (rsp.valid && rsp.ready) begin
        got.status = rsp.status;
        got.sample = rsp.sample_out;
        got.current_time = rsp.current_time;
        got.frame_end = rsp.frame_end;
        compared++;
        if (awaited_responses.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: response with nothing outstanding: status %0d sample %0d time %0h end %0b",
                     $realtime, got.status, $signed(got.sample), got.current_time, got.frame_end);
        end else begin
          want = awaited_responses.pop_front();
          if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: response %0d wrong (expected/actual): status %0d/%0d sample %0d/%0d time %0h/%0h end %0b/%0b",
                       $realtime, compared, want.status, got.status, $signed(want.sample),
                       $signed(got.sample), want.current_time, got.current_time,
                       want.frame_end, got.frame_end);
          end
        end
      end
    end
    outstanding = awaited_responses.size();
  end

endmodule

/* tb/tb_audio_mix_ring_buffer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audio_mix_ring_buffer_unit - regression bench of the mixing ring buffer
// Drives a short directed set, then random mix, read and restart traffic
// under seven register settings with random gaps on both channels, one long
// receiver stall, and quiet stretches; a checker module predicts and compares.
// ----------------------------------------------------------------------------
module tb_audio_mix_ring_buffer_unit;
  import amrb_pkg::*;

  localparam int DEPTH       = 4096;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int N_SETTINGS  = 7;

  typedef struct {
    logic [FUNC_W-1:0]  func;
    logic [TIME_W-1:0]  frame_time;
    logic [INDEX_W-1:0] sample_index;
    logic [NSAMP_W-1:0] frame_samples;
    logic [15:0]        sample_in;
  } beat_t;

  typedef struct {
    int unsigned spf;
    int unsigned period;
    int unsigned blen;
    logic [31:0] start;
    bit          restart;
    int unsigned beats;
  } setting_t;

  logic                   clk;
  logic                   rst;
  logic                   wr_en;
  logic [CFG_INDEX_W-1:0] wr_index;
  logic [CFG_DATA_W-1:0]  wr_data;

  amrb_req_if req_ch ();
  amrb_rsp_if rsp_ch ();

  int       mismatches;
  int       outstanding;
  int       compared;

  setting_t plan [N_SETTINGS];
  setting_t cur;
  logic [TIME_W-1:0] sh_now;
  int unsigned       sh_phase;
  bit       steady;
  bit       choke;
  int       n_mix;
  int       n_read;
  int       n_restart;
  int       cycles;

  audio_mix_ring_buffer_unit dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  amrb_mix_checker #(.DEPTH(DEPTH), .SW(16)) scoreboard (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .compared    (compared)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned at_least_one(int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  // mostly short gaps, a few long ones, none in a quiet stretch
  function automatic int draw_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic beat_t mk(logic [FUNC_W-1:0] func, logic [TIME_W-1:0] ftime,
      logic [INDEX_W-1:0] idx, logic [NSAMP_W-1:0] nsamp, logic [15:0] value);
    beat_t b;
    b.func = func;
    b.frame_time = ftime;
    b.sample_index = idx;
    b.frame_samples = nsamp;
    b.sample_in = value;
    return b;
  endfunction

  // mostly well-formed frames near the current time, plus late and noise beats
  function automatic beat_t draw_beat();
    beat_t       b;
    int unsigned r;
    int unsigned per;
    int unsigned spf;
    int unsigned len;
    int unsigned n;
    int unsigned k;
    per = at_least_one(cur.period);
    spf = at_least_one(cur.spf);
    len = (cur.blen < DEPTH) ? cur.blen : DEPTH;
    b.func = FUNC_READ;
    b.frame_time = $urandom;
    b.sample_index = INDEX_W'($urandom);
    b.frame_samples = NSAMP_W'($urandom);
    b.sample_in = ($urandom_range(0, 9) == 0) ?
                  ($urandom_range(0, 1) ? 16'h7FFF : 16'h8000) : 16'($urandom);
    n = $urandom_range(1, (spf > DEPTH) ? DEPTH : spf);
    r = $urandom_range(0, 99);
    if (r < 45) begin
      k = $urandom_range(0, len / spf + 1);
      b.func = FUNC_MIX_TIME;
      b.frame_time = sh_now + k * per + $urandom_range(0, per - 1);
      b.frame_samples = NSAMP_W'(n);
      b.sample_index = INDEX_W'($urandom_range(0, n - 1));
    end else if (r < 55) begin
      b.func = FUNC_MIX_START;
      b.frame_samples = NSAMP_W'(n);
      b.sample_index = INDEX_W'($urandom_range(0, n - 1));
    end else if (r < 85) begin
      b.func = FUNC_READ;
    end else if (r < 87) begin
      b.func = FUNC_RESTART;
    end else if (r < 93) begin
      b.func = FUNC_MIX_TIME;
      b.frame_time = sh_now - $urandom_range(1, 3 * per);
    end else begin
      b.func = ($urandom_range(0, 2) == 0) ? FUNC_READ :
               ($urandom_range(0, 1) ? FUNC_MIX_TIME : FUNC_MIX_START);
    end
    return b;
  endfunction

  // offer one beat after a random gap and hold it until taken
  task automatic offer(input beat_t b);
    int idle;
    idle = draw_gap();
    @(negedge clk);
    if (idle > 0) begin
      req_ch.valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.func <= b.func;
    req_ch.frame_time <= b.frame_time;
    req_ch.sample_index <= b.sample_index;
    req_ch.frame_samples <= b.frame_samples;
    req_ch.sample_in <= b.sample_in;
    do @(posedge clk); while (!req_ch.ready);
    // track the frame clock so that generated frames land near it
    case (b.func)
      FUNC_READ: begin
        n_read++;
        sh_phase++;
        if (sh_phase >= at_least_one(cur.spf)) begin
          sh_phase = 0;
          sh_now = sh_now + at_least_one(cur.period);
        end
      end
      FUNC_RESTART: begin
        n_restart++;
        sh_phase = 0;
        sh_now = cur.start;
      end
      default: n_mix++;
    endcase
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [31:0] value);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= index;
    wr_data <= value;
  endtask

  // receiver: random stalls, and one long hold-off to back the block up
  initial begin
    int  stall;
    bit  choked;
    rsp_ch.ready = 1'b0;
    stall = 0;
    choked = 1'b0;
    forever begin
      @(negedge clk);
      if (choke && !choked) begin
        choked = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (400) @(negedge clk);
      end else if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        stall--;
      end else begin
        rsp_ch.ready <= 1'b1;
        stall = draw_gap();
      end
    end
  end

  // run limit
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("audio_mix_ring_buffer_unit regression: fail");
    $finish;
  end

  initial begin
    beat_t directed [$];
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = CFG_SAMPLES_PER_FRAME;
    wr_data = '0;
    req_ch.valid = 1'b0;
    req_ch.func = FUNC_READ;
    req_ch.frame_time = '0;
    req_ch.sample_index = '0;
    req_ch.frame_samples = '0;
    req_ch.sample_in = '0;
    steady = 1'b0;
    choke = 1'b0;
    n_mix = 0;
    n_read = 0;
    n_restart = 0;
    sh_now = START_RESET;
    sh_phase = 0;

    // spf, period, length, start time, restart first, random beats
    plan[0] = '{80, 10, 800, 32'd0, 1'b0, 133};
    plan[1] = '{4, 1, 16, 32'hFFFF_FFF0, 1'b1, 133};
    plan[2] = '{1, 1000, 1, 32'h7FFF_FFF8, 1'b1, 133};
    plan[3] = '{4096, 3, 4096, 32'd100, 1'b1, 133};
    plan[4] = '{0, 0, 0, 32'd5, 1'b1, 133};
    plan[5] = '{8, 7, 8191, 32'd0, 1'b1, 133};
    plan[6] = '{16, 20, 12, 32'd1234, 1'b0, 133};

    // defaults, time zero: wrapping sums, edges of the ring, late and
    // too-far frames, index outside its frame, empty frame, then reads
    directed.push_back(mk(FUNC_MIX_TIME, 32'd0, 12'd0, 13'd80, 16'h7FFF));
    directed.push_back(mk(FUNC_MIX_TIME, 32'd5, 12'd0, 13'd80, 16'h0001));
    directed.push_back(mk(FUNC_MIX_START, 32'd0, 12'd79, 13'd80, 16'h8000));
    directed.push_back(mk(FUNC_MIX_TIME, 32'd95, 12'd79, 13'd80, 16'hFFFF));
    directed.push_back(mk(FUNC_MIX_TIME, 32'd100, 12'd0, 13'd80, 16'h0001));
    directed.push_back(mk(FUNC_MIX_TIME, 32'hFFFF_FFFF, 12'd0, 13'd80, 16'h0001));
    directed.push_back(mk(FUNC_MIX_TIME, 32'h8000_0000, 12'd0, 13'd80, 16'h0001));
    directed.push_back(mk(FUNC_MIX_TIME, 32'h7FFF_FFFF, 12'd0, 13'd80, 16'h0001));
    directed.push_back(mk(FUNC_MIX_START, 32'd0, 12'd4095, 13'd4096, 16'h0001));
    directed.push_back(mk(FUNC_MIX_START, 32'd0, 12'd5, 13'd0, 16'h0001));
    directed.push_back(mk(FUNC_MIX_START, 32'd0, 12'd80, 13'd80, 16'h0001));
    directed.push_back(mk(FUNC_MIX_START, 32'd0, 12'd0, 13'd8191, 16'h0001));
    directed.push_back(mk(FUNC_MIX_START, 32'd0, 12'd1, 13'd2, 16'h1234));
    directed.push_back(mk(FUNC_READ, 32'd0, 12'd0, 13'd0, 16'h0000));
    directed.push_back(mk(FUNC_READ, 32'd0, 12'd0, 13'd0, 16'h0000));
    directed.push_back(mk(FUNC_READ, 32'd0, 12'd0, 13'd0, 16'h0000));
    directed.push_back(mk(FUNC_MIX_TIME, 32'd10, 12'd3, 13'd80, 16'h4321));
    directed.push_back(mk(FUNC_RESTART, 32'd0, 12'd0, 13'd0, 16'h0000));
    directed.push_back(mk(FUNC_READ, 32'd0, 12'd0, 13'd0, 16'h0000));

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    for (int p = 0; p < N_SETTINGS; p++) begin
      cur = plan[p];
      // program every register while no request is outstanding
      write_reg(CFG_SAMPLES_PER_FRAME, cur.spf);
      write_reg(CFG_FRAME_PERIOD, cur.period);
      write_reg(CFG_BUFFER_LENGTH, cur.blen);
      write_reg(CFG_START_TIME, cur.start);
      @(negedge clk);
      wr_en <= 1'b0;

      if (cur.restart)
        offer(mk(FUNC_RESTART, '0, '0, '0, '0));
      if (p == 0)
        foreach (directed[i]) offer(directed[i]);

      for (int i = 0; i < cur.beats; i++) begin
        steady = (i >= 50 && i < 80);
        if (p == 1 && i == 10)
          choke = 1'b1;
        offer(draw_beat());
      end
      steady = 1'b0;

      // drain before the next register setting
      @(negedge clk);
      req_ch.valid <= 1'b0;
      wait (outstanding == 0);
      repeat (60) @(negedge clk);
    end

    $display("ran %0d mixes, %0d reads and %0d restarts over %0d register settings",
             n_mix, n_read, n_restart, N_SETTINGS);
    $display("compared %0d responses, %0d wrong or unexpected", compared, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("audio_mix_ring_buffer_unit regression: pass");
    end else begin
      $display("audio_mix_ring_buffer_unit regression: fail");
    end
    $finish;
  end

endmodule
